FILE: hw/rtl/first_fit_boundary_tag_allocator_macros.svh
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define FFTAG_ASSERT_IMM(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFTAG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fftag_pkg.sv
`timescale 1ns / 1ps

package fftag_pkg;

   localparam int WSIZE  = 4;
   localparam int DSIZE  = 8;
   // byte addresses carried wide and signed so that wrapped offsets fall outside the heap
   localparam int ADDR_W = 36;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NULL  = 2'd1,
      ST_NOFIT = 2'd2
   } status_type;

   // packed from the top down: status lands in the lowest bits
   typedef struct packed {
      logic [15:0] failures;
      logic [14:0] padded_bytes;
      logic [10:0] empty_blocks;
      logic [10:0] used_blocks;
      logic [13:0] block_addr;
      status_type  status;
   } rsp_type;

   function automatic logic [31:0] tag_size(input logic [31:0] w);
      return {w[31:3], 3'b000};
   endfunction

   function automatic logic [ADDR_W-1:0] ext32(input logic [31:0] v);
      return {{(ADDR_W-32){1'b0}}, v};
   endfunction

endpackage

FILE: hw/rtl/fftag_ram.sv
`timescale 1ns / 1ps

module fftag_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/fftag_seq.sv
`timescale 1ns / 1ps

`include "first_fit_boundary_tag_allocator_macros.svh"

module fftag_seq
   import fftag_pkg::*;
#(
   parameter int HEAP_BYTES = 16384,
   localparam int WORDS = HEAP_BYTES / 4,
   localparam int AW = $clog2(WORDS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_mode,
   input  logic [14:0]   req_size,
   input  logic [13:0]   req_addr,
   output logic          done_valid,
   input  logic          done_ready,
   output rsp_type       done_data,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [31:0]   mem_wdata,
   output logic          mem_re,
   output logic [AW-1:0] mem_raddr,
   input  logic [31:0]   mem_rdata
);

   localparam int CNT_W   = AW + 1;
   localparam int INIT_B  = ((HEAP_BYTES - 5 * WSIZE) / DSIZE) * DSIZE;
   localparam int FTR_IDX = (2 * WSIZE + INIT_B) / WSIZE;
   localparam int EPI_IDX = (3 * WSIZE + INIT_B) / WSIZE;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_RD, S_A_CHK, S_A_W0, S_A_W1, S_A_W2, S_A_W3,
      S_F_RD, S_F_DT, S_F_W0, S_F_W1,
      S_M_RD0, S_M_DT0, S_M_RD1, S_M_DT1, S_M_RD2, S_M_DT2,
      S_M_RD3, S_M_DT3, S_M_RD4, S_M_DT4,
      S_M_W0, S_M_RD5, S_M_DT5, S_M_W1,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  clr_ff;
   logic [15:0]       asize_ff;
   logic [ADDR_W-1:0] bp_ff, prev_ff, next_ff, w0_ff, w1_ff;
   logic [31:0]       csize_ff, fsz_ff, ps_ff, nsz_ff, sum_ff;
   logic              split_ff, palloc_ff, reread_ff, oor_ff;
   logic [10:0]       used_ff, empty_ff;
   logic [14:0]       pad_ff;
   logic [15:0]       fail_ff;
   status_type        status_ff;
   logic [13:0]       baddr_ff;

   logic [ADDR_W-1:0] ra, wa;
   logic [31:0]       wd, rword, rsize, alen, rest;
   logic              rd, wr, ralloc, fits, split;
   logic [15:0]       sz_ext, asize_new;
   logic [31:0]       sum_pa, sum_na, sum_bb;

   function automatic logic outside(input logic [ADDR_W-1:0] a);
      return a[ADDR_W-1] || (a[ADDR_W-1:2] >= (ADDR_W-2)'(WORDS));
   endfunction

   assign rword  = oor_ff ? 32'd1 : mem_rdata;
   assign rsize  = tag_size(rword);
   assign ralloc = rword[0];
   assign alen   = split_ff ? {16'd0, asize_ff} : csize_ff;
   assign rest   = csize_ff - {16'd0, asize_ff};
   assign fits   = !ralloc && ({16'd0, asize_ff} <= rsize);
   assign split  = (rsize - {16'd0, asize_ff}) >= 32'(2 * DSIZE);
   assign sz_ext = {1'b0, req_size};
   assign asize_new = (sz_ext <= 16'(DSIZE)) ? 16'(2 * DSIZE)
                                              : ((sz_ext + 16'(2 * DSIZE - 1)) & 16'hFFF8);
   assign sum_pa = tag_size(nsz_ff + rsize);
   assign sum_na = tag_size(nsz_ff + ps_ff);
   assign sum_bb = tag_size(nsz_ff + ps_ff + rsize);

   always_comb begin
      rd = 1'b0;
      wr = 1'b0;
      ra = bp_ff - ADDR_W'(WSIZE);
      wa = bp_ff - ADDR_W'(WSIZE);
      wd = sum_ff;
      case (state_ff)
         S_A_RD, S_F_RD, S_M_RD3: begin
            rd = 1'b1;
         end
         S_A_W0: begin
            wr = 1'b1;
            wd = alen | 32'd1;
         end
         S_A_W1: begin
            wr = 1'b1;
            wa = bp_ff + ext32(alen) - ADDR_W'(DSIZE);
            wd = alen | 32'd1;
         end
         S_A_W2: begin
            wr = 1'b1;
            wa = bp_ff + ext32({16'd0, asize_ff}) - ADDR_W'(WSIZE);
            wd = rest;
         end
         S_A_W3: begin
            wr = 1'b1;
            wa = bp_ff + ext32(csize_ff) - ADDR_W'(DSIZE);
            wd = rest;
         end
         S_F_W0: begin
            wr = 1'b1;
            wd = fsz_ff;
         end
         S_F_W1: begin
            wr = 1'b1;
            wa = bp_ff + ext32(fsz_ff) - ADDR_W'(DSIZE);
            wd = fsz_ff;
         end
         S_M_RD0: begin
            rd = 1'b1;
            ra = bp_ff - ADDR_W'(DSIZE);
         end
         S_M_RD1: begin
            rd = 1'b1;
            ra = prev_ff - ADDR_W'(WSIZE);
         end
         S_M_RD2: begin
            rd = 1'b1;
            ra = prev_ff + ext32(ps_ff) - ADDR_W'(DSIZE);
         end
         S_M_RD4, S_M_RD5: begin
            rd = 1'b1;
            ra = next_ff - ADDR_W'(WSIZE);
         end
         S_M_W0: begin
            wr = 1'b1;
            wa = w0_ff;
         end
         S_M_W1: begin
            wr = 1'b1;
            wa = w1_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mem_re    = rd;
      mem_raddr = ra[AW+1:2];
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff[AW-1:0];
         if (clr_ff == CNT_W'(1) || clr_ff == CNT_W'(2)) begin
            mem_wdata = 32'(DSIZE) | 32'd1;
         end else if (clr_ff == CNT_W'(3) || clr_ff == CNT_W'(FTR_IDX)) begin
            mem_wdata = 32'(INIT_B);
         end else if (clr_ff == CNT_W'(EPI_IDX)) begin
            mem_wdata = 32'd1;
         end else begin
            mem_wdata = 32'd0;
         end
      end else begin
         mem_we    = wr && !outside(wa);
         mem_waddr = wa[AW+1:2];
         mem_wdata = wd;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done_data  = '{failures: fail_ff, padded_bytes: pad_ff, empty_blocks: empty_ff,
                         used_blocks: used_ff, block_addr: baddr_ff, status: status_ff};

   always_ff @(posedge clock) begin
      oor_ff <= outside(ra);
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         used_ff   <= '0;
         empty_ff  <= 11'd1;
         pad_ff    <= '0;
         fail_ff   <= '0;
         status_ff <= ST_OK;
         baddr_ff  <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CNT_W'(1);
               if (clr_ff == CNT_W'(WORDS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  status_ff <= ST_OK;
                  baddr_ff  <= '0;
                  if (!req_mode) begin
                     if (req_size == '0) begin
                        status_ff <= ST_NULL;
                        if (fail_ff != 16'hFFFF) fail_ff <= fail_ff + 16'd1;
                        state_ff  <= S_DONE;
                     end else begin
                        asize_ff <= asize_new;
                        bp_ff    <= ADDR_W'(2 * DSIZE);
                        state_ff <= S_A_RD;
                     end
                  end else begin
                     if (req_addr == '0) begin
                        status_ff <= ST_NULL;
                        if (fail_ff != 16'hFFFF) fail_ff <= fail_ff + 16'd1;
                        state_ff  <= S_DONE;
                     end else begin
                        bp_ff    <= ADDR_W'(req_addr);
                        state_ff <= S_F_RD;
                     end
                  end
               end
            end
            S_A_RD: state_ff <= S_A_CHK;
            S_A_CHK: begin
               // first fit: one header per read
               if (rsize == '0) begin
                  status_ff <= ST_NOFIT;
                  if (fail_ff != 16'hFFFF) fail_ff <= fail_ff + 16'd1;
                  state_ff  <= S_DONE;
               end else if (fits) begin
                  csize_ff <= rsize;
                  split_ff <= split;
                  used_ff  <= used_ff + 11'd1;
                  pad_ff   <= pad_ff + 15'(asize_ff - 16'(DSIZE));
                  if (!split) empty_ff <= empty_ff - 11'd1;
                  baddr_ff <= bp_ff[13:0];
                  state_ff <= S_A_W0;
               end else begin
                  bp_ff    <= bp_ff + ext32(rsize);
                  state_ff <= S_A_RD;
               end
            end
            S_A_W0: state_ff <= S_A_W1;
            S_A_W1: state_ff <= split_ff ? S_A_W2 : S_DONE;
            S_A_W2: state_ff <= S_A_W3;
            S_A_W3: state_ff <= S_DONE;
            S_F_RD: state_ff <= S_F_DT;
            S_F_DT: begin
               fsz_ff   <= rsize;
               state_ff <= S_F_W0;
            end
            S_F_W0: state_ff <= S_F_W1;
            S_F_W1: begin
               used_ff  <= used_ff - 11'd1;
               pad_ff   <= pad_ff - 15'(fsz_ff - 32'(DSIZE));
               state_ff <= S_M_RD0;
            end
            S_M_RD0: state_ff <= S_M_DT0;
            S_M_DT0: begin
               prev_ff  <= bp_ff - ext32(rsize);
               state_ff <= S_M_RD1;
            end
            S_M_RD1: state_ff <= S_M_DT1;
            S_M_DT1: begin
               ps_ff    <= rsize;
               state_ff <= S_M_RD2;
            end
            S_M_RD2: state_ff <= S_M_DT2;
            S_M_DT2: begin
               palloc_ff <= ralloc;
               state_ff  <= S_M_RD3;
            end
            S_M_RD3: state_ff <= S_M_DT3;
            S_M_DT3: begin
               nsz_ff   <= rsize;
               next_ff  <= bp_ff + ext32(rsize);
               state_ff <= S_M_RD4;
            end
            S_M_RD4: state_ff <= S_M_DT4;
            S_M_DT4: begin
               reread_ff <= 1'b0;
               if (palloc_ff && ralloc) begin
                  empty_ff <= empty_ff + 11'd1;
                  state_ff <= S_DONE;
               end else if (palloc_ff) begin
                  sum_ff   <= sum_pa;
                  w0_ff    <= bp_ff - ADDR_W'(WSIZE);
                  w1_ff    <= bp_ff + ext32(sum_pa) - ADDR_W'(DSIZE);
                  state_ff <= S_M_W0;
               end else if (ralloc) begin
                  sum_ff   <= sum_na;
                  w0_ff    <= bp_ff + ext32(nsz_ff) - ADDR_W'(DSIZE);
                  w1_ff    <= prev_ff - ADDR_W'(WSIZE);
                  state_ff <= S_M_W0;
               end else begin
                  // next header read again after the prev header write, to locate the next footer
                  sum_ff    <= sum_bb;
                  w0_ff     <= prev_ff - ADDR_W'(WSIZE);
                  reread_ff <= 1'b1;
                  empty_ff  <= empty_ff - 11'd1;
                  state_ff  <= S_M_W0;
               end
            end
            S_M_W0: state_ff <= reread_ff ? S_M_RD5 : S_M_W1;
            S_M_RD5: state_ff <= S_M_DT5;
            S_M_DT5: begin
               w1_ff    <= next_ff + ext32(rsize) - ADDR_W'(DSIZE);
               state_ff <= S_M_W1;
            end
            S_M_W1: state_ff <= S_DONE;
            S_DONE: begin
               if (done_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `FFTAG_ASSERT_NEXT(a_req_leaves_idle, req_valid && req_ready, state_ff != S_IDLE, "request did not start work")
   `FFTAG_ASSERT_IMM(a_port_exclusive, mem_we, !mem_re, "read and write in one cycle")
   `FFTAG_ASSERT_IMM(a_fail_monotonic, !$past(reset), fail_ff >= $past(fail_ff), "failure count fell")

endmodule

FILE: hw/rtl/first_fit_boundary_tag_allocator.sv
`timescale 1ns / 1ps

// channel   direction  contents
// req_      in         tdata: req_size[14:0], release_addr[28:15]; tuser: mode
// rsp_      out        tdata: status, block_addr, used, empty, padded, failures
//
// an allocation walks the block headers one read at a time, then writes two tags, four when it splits
// a free is a chain of reads and writes on the one tag ram
// after reset a clearing pass writes all HEAP_BYTES/4 tag words to build the initial heap; req_tready low
// the result sits in an output register, so the next request starts while it waits

module first_fit_boundary_tag_allocator
   import fftag_pkg::*;
#(
   parameter int HEAP_BYTES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // req_size, release_addr
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // status, block_addr, used_blocks, empty_blocks,
                                    // padded_bytes, failures
);

   localparam int WORDS = HEAP_BYTES / 4;
   localparam int AW    = $clog2(WORDS);

   logic          done_valid, done_ready;
   rsp_type       done_data, rsp_data_ff;
   logic          rsp_valid_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata, mem_rdata;

   fftag_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_size   (req_tdata[14:0]),
      .req_addr   (req_tdata[28:15]),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   fftag_ram #(.WIDTH(32), .DEPTH(WORDS)) u_tags (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
      if (done_valid && done_ready) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fftag_pkg::*;

   localparam int HEAP = 16384;
   localparam int TAGS = HEAP / 4;
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // heap shadow: tag words, block counters, expected responses in order
   class heap_scoreboard;
      bit [31:0]   tags [TAGS];
      bit [10:0]   used_n;
      bit [10:0]   empty_n;
      bit [14:0]   padded_n;
      bit [15:0]   fail_n;
      rsp_type     pending [$];
      bit [13:0]   last_block;

      function new();
         bit [31:0] b;
         b = (HEAP - 5 * WSIZE) & ~32'h7;
         foreach (tags[i]) tags[i] = '0;
         put(4, DSIZE | 1);
         put(8, DSIZE | 1);
         put(12, b);
         put(12 + b - 4, b);
         put(12 + b, 1);
         used_n = 0; empty_n = 1; padded_n = 0; fail_n = 0;
      endfunction

      // words past the heap read as a size-zero allocated tag
      function bit [31:0] get(longint unsigned a);
         longint unsigned i;
         i = a >> 2;
         return (i < TAGS) ? tags[i] : 32'h1;
      endfunction

      function void put(longint unsigned a, bit [31:0] v);
         longint unsigned i;
         i = a >> 2;
         if (i < TAGS) tags[i] = v;
      endfunction

      function bit [31:0] sz(longint unsigned a);
         return get(a) & ~32'h7;
      endfunction

      function void bump_fail();
         if (fail_n != 16'hFFFF) fail_n++;
      endfunction

      function void coalesce(longint unsigned bp);
         longint unsigned prv, nxt;
         bit p_used, n_used;
         bit [31:0] s;
         prv = bp - sz(bp - DSIZE);
         p_used = 1'(get(prv + sz(prv - WSIZE) - DSIZE) & 32'h1);
         nxt = bp + sz(bp - WSIZE);
         n_used = 1'(get(nxt - WSIZE) & 32'h1);
         s = sz(bp - WSIZE);
         if (p_used && n_used) begin
            empty_n++;
         end else if (p_used) begin
            s += sz(nxt - WSIZE);
            put(bp - WSIZE, s & ~32'h7);
            put(bp + (s & ~32'h7) - DSIZE, s & ~32'h7);
         end else if (n_used) begin
            s += sz(prv - WSIZE);
            put(bp + sz(bp - WSIZE) - DSIZE, s & ~32'h7);
            put(prv - WSIZE, s & ~32'h7);
         end else begin
            s += sz(prv - WSIZE);
            s += sz(nxt - WSIZE);
            put(prv - WSIZE, s & ~32'h7);
            put(nxt + sz(nxt - WSIZE) - DSIZE, s & ~32'h7);
            empty_n--;
         end
      endfunction

      function void note(bit mode, bit [14:0] size, bit [13:0] addr);
         rsp_type r;
         longint unsigned bp;
         bit [31:0] asz, csz, s;
         bit found;
         r = '0;
         r.status = ST_OK;
         if (mode == MODE_ALLOC) begin
            if (size == 0) begin
               r.status = ST_NULL;
               bump_fail();
            end else begin
               asz = (size <= DSIZE) ? 2 * DSIZE : DSIZE * ((size + 2 * DSIZE - 1) / DSIZE);
               bp = 16;
               found = 0;
               forever begin
                  s = sz(bp - WSIZE);
                  if (s == 0) break;
                  if (!(get(bp - WSIZE) & 1) && asz <= s) begin
                     found = 1;
                     break;
                  end
                  bp += s;
               end
               if (found) begin
                  csz = sz(bp - WSIZE);
                  used_n++;
                  padded_n = 15'(padded_n + asz - DSIZE);
                  if (csz - asz >= 2 * DSIZE) begin
                     put(bp - WSIZE, asz | 1);
                     put(bp + asz - DSIZE, asz | 1);
                     put(bp + asz - WSIZE, csz - asz);
                     put(bp + csz - DSIZE, csz - asz);
                  end else begin
                     put(bp - WSIZE, csz | 1);
                     put(bp + csz - DSIZE, csz | 1);
                     empty_n--;
                  end
                  r.block_addr = bp[13:0];
               end else begin
                  r.status = ST_NOFIT;
                  bump_fail();
               end
            end
         end else begin
            if (addr == 0) begin
               r.status = ST_NULL;
               bump_fail();
            end else begin
               bp = addr;
               s = sz(bp - WSIZE);
               put(bp - WSIZE, s);
               put(bp + s - DSIZE, s);
               used_n--;
               padded_n = 15'(padded_n - (s - DSIZE));
               coalesce(bp);
            end
         end
         r.used_blocks = used_n;
         r.empty_blocks = empty_n;
         r.padded_bytes = padded_n;
         r.failures = fail_n;
         last_block = r.block_addr;
         pending.push_back(r);
      endfunction

      // returns 1 on mismatch, with a description
      function bit check(rsp_type got, output string why);
         rsp_type exp;
         why = "";
         if (pending.size() == 0) begin
            why = $sformatf("unexpected response %p", got);
            return 1;
         end
         exp = pending.pop_front();
         if (got.status != exp.status)
            why = {why, $sformatf(" status %0d/%0d", got.status, exp.status)};
         if (got.block_addr != exp.block_addr)
            why = {why, $sformatf(" block_addr %0d/%0d", got.block_addr, exp.block_addr)};
         if (got.used_blocks != exp.used_blocks)
            why = {why, $sformatf(" used %0d/%0d", got.used_blocks, exp.used_blocks)};
         if (got.empty_blocks != exp.empty_blocks)
            why = {why, $sformatf(" empty %0d/%0d", got.empty_blocks, exp.empty_blocks)};
         if (got.padded_bytes != exp.padded_bytes)
            why = {why, $sformatf(" padded %0d/%0d", got.padded_bytes, exp.padded_bytes)};
         if (got.failures != exp.failures)
            why = {why, $sformatf(" failures %0d/%0d", got.failures, exp.failures)};
         return why != "";
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   heap_scoreboard heap_sb;
   int          mismatches;
   int          idle_pct;
   int          stall_pct;
   int          hold_cycles;
   bit [13:0]   live_blocks [$];

   first_fit_boundary_tag_allocator u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("first_fit_boundary_tag_allocator regression: fail");
      $finish;
   end

   task automatic report(string what);
      $display("mismatch at %0t:%s", $realtime, what);
      mismatches++;
   endtask

   // response side: stall at random, or hold off for a counted stretch
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 0;
            hold_cycles--;
         end else begin
            rsp_tready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      string why;
      if (!reset && rsp_tvalid && rsp_tready)
         if (heap_sb.check(rsp_type'(rsp_tdata[68:0]), why)) report(why);
   end

   task automatic send(bit mode, bit [14:0] size, bit [13:0] addr);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_tvalid = 1;
      req_tuser  = mode;
      req_tdata  = {3'b000, addr, size};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      heap_sb.note(mode, size, addr);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic alloc(bit [14:0] size);
      send(MODE_ALLOC, size, '0);
      if (heap_sb.last_block != 0) live_blocks.push_back(heap_sb.last_block);
   endtask

   task automatic release_block(bit [13:0] addr);
      int k;
      for (k = 0; k < live_blocks.size(); k++)
         if (live_blocks[k] == addr) begin
            live_blocks.delete(k);
            break;
         end
      send(MODE_FREE, '0, addr);
   endtask

   task automatic drain();
      while (heap_sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic random_item(bit noisy);
      int r;
      bit [14:0] size;
      r = $urandom_range(99);
      if (noisy && r < 8) begin
         send(MODE_FREE, '0, 14'($urandom_range(16383, 1)));
      end else if (r < 12) begin
         send(1'($urandom_range(1)), '0, '0);
      end else if (live_blocks.size() != 0 && r < 55) begin
         release_block(live_blocks[$urandom_range(live_blocks.size() - 1)]);
      end else begin
         r = $urandom_range(99);
         if (r < 70)      size = 15'($urandom_range(64, 1));
         else if (r < 95) size = 15'($urandom_range(512, 65));
         else             size = 15'($urandom_range(32767, 513));
         alloc(size);
      end
   endtask

   initial begin
      bit [13:0] blk [4];
      int ph, n;
      mismatches = 0;
      hold_cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      heap_sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // edge sizes and null requests
      alloc(0);
      send(MODE_FREE, '0, '0);
      alloc(32767);
      alloc(16384);
      alloc(1);
      alloc(8);
      alloc(9);
      alloc(24);
      while (live_blocks.size() != 0) release_block(live_blocks[0]);
      // two frees with no merge, then two double merges
      for (n = 0; n < 4; n++) begin alloc(16); blk[n] = heap_sb.last_block; end
      release_block(blk[0]);
      release_block(blk[2]);
      release_block(blk[1]);
      release_block(blk[3]);
      // no merge, previous block only, following block only, then both
      for (n = 0; n < 4; n++) begin alloc(40); blk[n] = heap_sb.last_block; end
      release_block(blk[0]);
      release_block(blk[1]);
      release_block(blk[3]);
      release_block(blk[2]);
      // exact fit of the whole heap, no split
      alloc(16352);
      release_block(heap_sb.last_block);
      drain();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         for (n = 0; n < 110; n++) begin
            if (n % 40 == 0 && n != 0) begin
               idle_pct = 0;
               hold_cycles = 300;
            end
            if (n % 40 == 20) begin
               drain();
               idle_pct = (ph == 1) ? 71 : (ph == 3) ? 27 : 0;
            end
            // the first three phases stay well formed; only the last adds frees at random addresses
            random_item(ph == 3);
         end
      end

      drain();
      repeat (100) @(negedge clock);
      if (mismatches == 0 && heap_sb.pending.size() == 0) begin
         $display("first_fit_boundary_tag_allocator regression: pass");
      end else begin
         $display("first_fit_boundary_tag_allocator regression: fail");
      end
      $finish;
   end

endmodule
